>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the dispatch tracker.
// No dependencies; take it in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define DND_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dispatch tracker assertion failed");

// Next-cycle implication, held off while reset is low.
`define DND_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dispatch tracker assertion failed");

`endif

>>> rtl/dnd_pkg.sv
// Package of the task graph dispatch tracker: sizes, codes and types.
// No dependencies; used by the interfaces, the top level and the checker.
package dnd_pkg;

  // Graph limits
  localparam int MAX_NODES     = 16;
  localparam int MAX_SEQUENCES = 8;

  // Derived sizes
  localparam int NODE_W  = $clog2(MAX_NODES + 1);   // node number 0..MAX_NODES
  localparam int NIDX_W  = $clog2(MAX_NODES);       // node index / row address
  localparam int ROW_W   = MAX_NODES - 1;           // predecessor bits per row
  localparam int ROW_DEP = 2 ** NIDX_W;             // row memory depth
  localparam int SLOTS   = MAX_SEQUENCES - 1;       // head slots
  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed field widths
  localparam int OP_W    = 3;
  localparam int RBITS_W = 15;
  localparam int HSLOT_W = 3;
  localparam int STAT_W  = 2;
  localparam int SEQ_W   = 3;
  localparam int NCNT_W  = 5;
  localparam int SCNT_W  = 4;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_NEW_JOB    = 3'd0,
    OP_TRY_START  = 3'd1,
    OP_FINISH     = 3'd2,
    OP_CHECK      = 3'd3,
    OP_WRITE_ROW  = 3'd4,
    OP_WRITE_HEAD = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STS_STARTED = 2'd0,
    STS_BLOCKED = 2'd1,
    STS_RUNNING = 2'd2,
    STS_ACK     = 2'd3
  } status_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_NODE_COUNT  = 2'd0,
    CFG_SEQ_COUNT   = 2'd1,
    CFG_AUTO_SIGNAL = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FIN
  } state_e;

  typedef struct packed {
    status_e           status;
    logic              ready_res;
    logic              signal_valid;
    logic [SEQ_W-1:0]  signal_sequence;
    logic              last;
  } result_t;

endpackage

>>> rtl/dnd_if.sv
// Handshake channels of the dispatch tracker: request, result and config.
// Depends on dnd_pkg for field widths.
interface dnd_in_if;
  logic                         valid;
  logic                         ready;
  logic [dnd_pkg::OP_W-1:0]     operation;
  logic [dnd_pkg::NODE_W-1:0]   node;
  logic [dnd_pkg::RBITS_W-1:0]  row_bits;
  logic [dnd_pkg::HSLOT_W-1:0]  head_slot;
  modport source (output valid, operation, node, row_bits, head_slot, input ready);
  modport sink   (input valid, operation, node, row_bits, head_slot, output ready);
endinterface

interface dnd_out_if;
  logic                         valid;
  logic                         ready;
  logic [dnd_pkg::STAT_W-1:0]   status;
  logic                         ready_res;
  logic                         signal_valid;
  logic [dnd_pkg::SEQ_W-1:0]    signal_sequence;
  logic                         last;
  modport source (output valid, status, ready_res, signal_valid, signal_sequence, last,
                  input ready);
  modport sink   (input valid, status, ready_res, signal_valid, signal_sequence, last,
                  output ready);
endinterface

interface dnd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dnd_pkg::CIDX_W-1:0]   index;
  logic [dnd_pkg::CDAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/dag_node_dispatch_tracker.sv
// Dispatch tracker for one job of a task graph: start, finish and readiness
// requests against a precedence row memory. Depends on dnd_pkg and dnd_if.
//
// One request word is handled at a time. New job, table writes, try start,
// check and a finish that wakes nothing pass through S_IDLE, which accepts
// the word and reads the node's row from the row memory, and S_EXEC, which
// evaluates and loads the result register. A finish that may wake sequences
// walks the rows of nodes 2..node_count one row per cycle (the row read is
// registered), staying on a row while it still has wake words to send and
// while a stalled receiver holds a wake word back, then closes in S_FIN.
// The row memory needs no clearing pass; per-row valid bits make unwritten
// rows read as zero straight after reset. Config writes are taken at any time
// but must only be issued while the block is idle.
module dag_node_dispatch_tracker (
  input  logic  clk_i,
  input  logic  rst_ni,
  dnd_in_if.sink     in_i,
  dnd_out_if.source  res_o,
  dnd_cfg_if.sink    cfg_i
);

  // Config registers
  logic [dnd_pkg::NCNT_W-1:0] node_count_q;
  logic [dnd_pkg::SCNT_W-1:0] seq_count_q;
  logic                       auto_sig_q;

  // Job state
  logic [dnd_pkg::MAX_NODES-1:0] fin_q, fin_d;
  logic [dnd_pkg::MAX_NODES-1:0] run_q, run_d;
  logic [dnd_pkg::NODE_W-1:0]    head_q [dnd_pkg::SLOTS];

  // Precedence row memory and its read port
  logic [dnd_pkg::ROW_W-1:0]   row_mem [dnd_pkg::ROW_DEP];
  logic [dnd_pkg::ROW_DEP-1:0] row_vld_q;
  logic [dnd_pkg::ROW_W-1:0]   rdata_q;
  logic                        rvld_q;
  logic                        rd_en;
  logic [dnd_pkg::NIDX_W-1:0]  rd_addr;
  logic                        wr_en;
  logic [dnd_pkg::NIDX_W-1:0]  wr_addr;
  logic [dnd_pkg::ROW_W-1:0]   row_eff;

  // Sequencer
  dnd_pkg::state_e             state_q, state_d;
  dnd_pkg::op_e                op_q, op_d;
  logic [dnd_pkg::NODE_W-1:0]  node_q, node_d;
  logic [dnd_pkg::NIDX_W-1:0]  x_q, x_d;
  logic [dnd_pkg::SLOTS-1:0]   done_q, done_d;
  logic                        pend_v_q, pend_v_d;
  logic [dnd_pkg::SEQ_W-1:0]   pend_seq_q, pend_seq_d;

  // Result register
  logic             out_v_q, out_v_d;
  dnd_pkg::result_t res_q, res_d;
  logic             out_free;

  // Derived values
  logic [dnd_pkg::NODE_W-1:0] eff_n;
  logic [dnd_pkg::SCNT_W-1:0] eff_s;
  logic [dnd_pkg::ROW_W-1:0]  low_mask;
  logic                       in_acc;
  logic                       in_node_ok;
  logic [dnd_pkg::MAX_NODES-1:0] in_bit;
  logic                       head_we;

  function automatic logic prec_pass(input logic [dnd_pkg::ROW_W-1:0] row,
                                     input logic [dnd_pkg::ROW_W-1:0] mask,
                                     input logic [dnd_pkg::ROW_W-1:0] fin);
    logic [dnd_pkg::ROW_W-1:0] need;
    need = row & mask;
    return (need & fin) == need;
  endfunction

  // Clamp config to legal ranges
  always_comb begin
    if (node_count_q == '0) begin
      eff_n = dnd_pkg::NODE_W'(1);
    end else if (node_count_q > dnd_pkg::NCNT_W'(dnd_pkg::MAX_NODES)) begin
      eff_n = dnd_pkg::NODE_W'(dnd_pkg::MAX_NODES);
    end else begin
      eff_n = dnd_pkg::NODE_W'(node_count_q);
    end
    if (seq_count_q == '0) begin
      eff_s = dnd_pkg::SCNT_W'(1);
    end else if (seq_count_q > dnd_pkg::SCNT_W'(dnd_pkg::MAX_SEQUENCES)) begin
      eff_s = dnd_pkg::SCNT_W'(dnd_pkg::MAX_SEQUENCES);
    end else begin
      eff_s = seq_count_q;
    end
    low_mask = dnd_pkg::ROW_W'((64'd1 << (eff_n - 1'b1)) - 64'd1);
  end

  // Config port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= dnd_pkg::NCNT_W'(dnd_pkg::MAX_NODES);
      seq_count_q  <= dnd_pkg::SCNT_W'(1);
      auto_sig_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      case (dnd_pkg::cfg_idx_e'(cfg_i.index))
        dnd_pkg::CFG_NODE_COUNT:  node_count_q <= cfg_i.data[dnd_pkg::NCNT_W-1:0];
        dnd_pkg::CFG_SEQ_COUNT:   seq_count_q  <= cfg_i.data[dnd_pkg::SCNT_W-1:0];
        dnd_pkg::CFG_AUTO_SIGNAL: auto_sig_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Request side decode
  assign in_i.ready = (state_q == dnd_pkg::S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_node_ok = (in_i.node != '0) && (in_i.node <= eff_n);
  assign in_bit     = dnd_pkg::MAX_NODES'(1) << (in_i.node - 1'b1);
  assign wr_en      = in_acc && (dnd_pkg::op_e'(in_i.operation) == dnd_pkg::OP_WRITE_ROW)
                      && in_node_ok && (in_i.node >= dnd_pkg::NODE_W'(2));
  assign wr_addr    = dnd_pkg::NIDX_W'(in_i.node - dnd_pkg::NODE_W'(2));
  assign head_we    = in_acc && (dnd_pkg::op_e'(in_i.operation) == dnd_pkg::OP_WRITE_HEAD)
                      && (in_i.head_slot < dnd_pkg::HSLOT_W'(dnd_pkg::SLOTS));

  // Row memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[wr_addr] <= in_i.row_bits[dnd_pkg::ROW_W-1:0];
    end
    if (rd_en) begin
      rdata_q <= row_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= row_vld_q[rd_addr];
      end
    end
  end

  // Unwritten rows read as zero
  assign row_eff = rvld_q ? rdata_q : '0;

  // Head table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dnd_pkg::SLOTS; i++) begin
        head_q[i] <= '0;
      end
    end else if (head_we) begin
      head_q[in_i.head_slot[dnd_pkg::SLOT_IW-1:0]] <= in_i.node;
    end
  end

  assign out_free = !out_v_q || res_o.ready;

  // Sequencer: next state, memory read and result loading
  always_comb begin
    logic                        node_ok;
    logic [dnd_pkg::NIDX_W-1:0]  nidx;
    logic                        prec_node;
    logic [dnd_pkg::NODE_W-1:0]  x_node;
    logic                        hit;
    logic [dnd_pkg::SLOTS-1:0]   match;
    logic [dnd_pkg::SLOTS-1:0]   avail;
    logic [dnd_pkg::SLOT_IW-1:0] pick;
    logic                        load;
    dnd_pkg::result_t            nres;

    state_d    = state_q;
    op_d       = op_q;
    node_d     = node_q;
    x_d        = x_q;
    done_d     = done_q;
    pend_v_d   = pend_v_q;
    pend_seq_d = pend_seq_q;
    fin_d      = fin_q;
    run_d      = run_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    load       = 1'b0;
    nres       = '{status: dnd_pkg::STS_ACK, ready_res: 1'b0, signal_valid: 1'b0,
                   signal_sequence: '0, last: 1'b1};

    node_ok   = (node_q != '0) && (node_q <= eff_n);
    nidx      = dnd_pkg::NIDX_W'(node_q - 1'b1);
    prec_node = (node_q == dnd_pkg::NODE_W'(1))
                || prec_pass(row_eff, low_mask, fin_q[dnd_pkg::ROW_W-1:0]);
    x_node    = dnd_pkg::NODE_W'(x_q) + dnd_pkg::NODE_W'(2);
    hit       = row_eff[nidx] && prec_pass(row_eff, low_mask, fin_q[dnd_pkg::ROW_W-1:0]);
    for (int i = 0; i < dnd_pkg::SLOTS; i++) begin
      match[i] = (head_q[i] == x_node) && ((i + 1) < int'(eff_s));
    end
    avail = hit ? (match & ~done_q) : '0;
    pick  = '0;
    for (int i = dnd_pkg::SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pick = dnd_pkg::SLOT_IW'(i);
      end
    end

    case (state_q)
      // Take a word, apply mask and table updates, read the node's row
      dnd_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d    = dnd_pkg::op_e'(in_i.operation);
          node_d  = in_i.node;
          rd_en   = 1'b1;
          rd_addr = dnd_pkg::NIDX_W'(in_i.node - dnd_pkg::NODE_W'(2));
          case (dnd_pkg::op_e'(in_i.operation))
            dnd_pkg::OP_NEW_JOB: begin
              fin_d = '0;
              run_d = '0;
            end
            dnd_pkg::OP_FINISH: begin
              if (in_node_ok) begin
                fin_d = fin_q | in_bit;
              end
            end
            default: ;
          endcase
          state_d = dnd_pkg::S_EXEC;
        end
      end

      // Evaluate single-word operations, or start the successor walk
      dnd_pkg::S_EXEC: begin
        if (op_q == dnd_pkg::OP_FINISH && node_ok && auto_sig_q && node_q != eff_n
            && eff_s > dnd_pkg::SCNT_W'(1)) begin
          rd_en    = 1'b1;
          rd_addr  = '0;
          x_d      = '0;
          done_d   = '0;
          pend_v_d = 1'b0;
          state_d  = dnd_pkg::S_WALK;
        end else if (out_free) begin
          load = 1'b1;
          case (op_q)
            dnd_pkg::OP_TRY_START: begin
              if (!node_ok || !prec_node) begin
                nres.status = dnd_pkg::STS_BLOCKED;
              end else if (run_q[nidx]) begin
                nres.status = dnd_pkg::STS_RUNNING;
              end else begin
                nres.status = dnd_pkg::STS_STARTED;
                run_d[nidx] = 1'b1;
              end
            end
            dnd_pkg::OP_CHECK: begin
              nres.ready_res = node_ok && prec_node;
            end
            default: ;
          endcase
          state_d = dnd_pkg::S_IDLE;
        end
      end

      // One row per cycle unless wake words or a stalled receiver hold it;
      // wake words are held back one step so the final is marked last
      dnd_pkg::S_WALK: begin
        if (avail != '0) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              load                 = 1'b1;
              nres.signal_valid    = 1'b1;
              nres.signal_sequence = pend_seq_q;
              nres.last            = 1'b0;
            end
            pend_v_d     = 1'b1;
            pend_seq_d   = dnd_pkg::SEQ_W'(pick) + dnd_pkg::SEQ_W'(1);
            done_d[pick] = 1'b1;
          end
        end else if (x_node == eff_n) begin
          state_d = dnd_pkg::S_FIN;
        end else begin
          x_d     = x_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = x_q + 1'b1;
          done_d  = '0;
        end
      end

      // Closing word of a walk
      dnd_pkg::S_FIN: begin
        if (out_free) begin
          load = 1'b1;
          if (pend_v_q) begin
            nres.signal_valid    = 1'b1;
            nres.signal_sequence = pend_seq_q;
          end
          state_d = dnd_pkg::S_IDLE;
        end
      end

      default: state_d = dnd_pkg::S_IDLE;
    endcase

    // Result register
    if (load) begin
      out_v_d = 1'b1;
      res_d   = nres;
    end else begin
      out_v_d = out_v_q && !res_o.ready;
      res_d   = res_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dnd_pkg::S_IDLE;
      fin_q    <= '0;
      run_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fin_q    <= fin_d;
      run_q    <= run_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    node_q     <= node_d;
    x_q        <= x_d;
    done_q     <= done_d;
    pend_seq_q <= pend_seq_d;
    res_q      <= res_d;
  end

  // Result port
  assign res_o.valid           = out_v_q;
  assign res_o.status          = res_q.status;
  assign res_o.ready_res       = res_q.ready_res;
  assign res_o.signal_valid    = res_q.signal_valid;
  assign res_o.signal_sequence = res_q.signal_sequence;
  assign res_o.last            = res_q.last;

endmodule

>>> rtl/dnd_checker.sv
// Port-level checker for the dispatch tracker, bound to the top level.
// Depends on dnd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dnd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dnd_pkg::STAT_W-1:0]  out_status,
  input logic                        out_ready_res,
  input logic                        out_signal_valid,
  input logic [dnd_pkg::SEQ_W-1:0]   out_signal_sequence,
  input logic                        out_last
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] open_q;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Request words whose last result word is not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + {1'b0, in_acc} - {1'b0, out_acc && out_last};
    end
  end

  `DND_ASSERT_IMP(a_no_orphan_word, clk_i, rst_ni, out_acc, open_q != 2'd0)
  `DND_ASSERT_IMP(a_mid_word_is_wake, clk_i, rst_ni, out_valid && !out_last, out_signal_valid && out_status == dnd_pkg::STS_ACK)
  `DND_ASSERT_IMP(a_wake_has_seq, clk_i, rst_ni, out_valid && out_signal_valid, out_signal_sequence != '0 && !out_ready_res)
  `DND_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_signal_sequence) && $stable(out_last))

endmodule

bind dag_node_dispatch_tracker dnd_checker u_dnd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid            (in_i.valid),
  .in_ready            (in_i.ready),
  .out_valid           (res_o.valid),
  .out_ready           (res_o.ready),
  .out_status          (res_o.status),
  .out_ready_res       (res_o.ready_res),
  .out_signal_valid    (res_o.signal_valid),
  .out_signal_sequence (res_o.signal_sequence),
  .out_last            (res_o.last)
);

>>> test/tb_dag_node_dispatch_tracker.sv
// Testbench of the task graph dispatch tracker: directed words, then random jobs
// checked word by word against a predictor. Depends on dnd_pkg, dnd_if and the RTL.
module tb_dag_node_dispatch_tracker;
  import dnd_pkg::*;

  // Opcodes the block does not define; it must just acknowledge them
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;
  localparam int HOLD_CYCLES = 120;

  // One row of the directed plan: a request word or a register write
  typedef struct packed {
    bit                 is_cfg;
    cfg_idx_e           reg_idx;
    logic [CDAT_W-1:0]  reg_val;
    logic [OP_W-1:0]    op;
    logic [NODE_W-1:0]  node;
    logic [RBITS_W-1:0] bits;
    logic [HSLOT_W-1:0] slot;
    bit                 pinned;
    status_e            want_status;
    bit                 want_ready;
  } step_t;

  logic clk_i;
  logic rst_ni;

  dnd_in_if  req_if ();
  dnd_out_if res_if ();
  dnd_cfg_if cfg_if ();

  dag_node_dispatch_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Tracker state as the block should hold it
  logic [MAX_NODES-1:0] fin_mask;
  logic [MAX_NODES-1:0] run_mask;
  logic [ROW_W-1:0]     prec_rows [ROW_W];
  logic [NODE_W-1:0]    head_nodes [SLOTS];
  logic [NCNT_W-1:0]    cfg_nodes;
  logic [SCNT_W-1:0]    cfg_seqs;
  logic                 cfg_auto;

  result_t pending_results [$];
  int      mismatch_cnt;
  int      words_sent;

  // Directed rows may carry a typed-in answer instead of the predicted one
  bit      pin_on;
  result_t pin_res;

  // Idle rates and receiver hold-off requests
  int src_idle_pct;
  int snk_idle_pct;
  int stall_req;
  int stall_seen;
  int hold_left;

  step_t plan [$];

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned eff_nodes();
    if (cfg_nodes < 1) return 1;
    if (cfg_nodes > MAX_NODES) return MAX_NODES;
    return 32'(cfg_nodes);
  endfunction

  function automatic int unsigned eff_seqs();
    if (cfg_seqs < 1) return 1;
    if (cfg_seqs > MAX_SEQUENCES) return MAX_SEQUENCES;
    return 32'(cfg_seqs);
  endfunction

  function automatic bit node_in_use(int unsigned n);
    return n >= 1 && n <= eff_nodes();
  endfunction

  // Node 1 has no row; predecessors beyond the node count are ignored
  function automatic bit preds_done(int unsigned n);
    logic [ROW_W-1:0] need;
    if (n == 1) return 1'b1;
    need = prec_rows[n-2] & ROW_W'((1 << (eff_nodes() - 1)) - 1);
    return (need & fin_mask[ROW_W-1:0]) == need;
  endfunction

  // Apply one request word and queue the result words it should produce
  function automatic void track_dispatch(logic [OP_W-1:0] op, logic [NODE_W-1:0] node,
                                         logic [RBITS_W-1:0] bits, logic [HSLOT_W-1:0] slot);
    int unsigned n;
    int unsigned s;
    int unsigned nd;
    int unsigned wake [$];
    result_t     r;
    n  = eff_nodes();
    s  = eff_seqs();
    nd = 32'(node);
    r = '{status: STS_ACK, ready_res: 1'b0, signal_valid: 1'b0, signal_sequence: '0,
          last: 1'b1};
    case (op)
      OP_NEW_JOB: begin
        fin_mask = '0;
        run_mask = '0;
      end
      OP_TRY_START: begin
        if (!node_in_use(nd)) r.status = STS_BLOCKED;
        else if (!preds_done(nd)) r.status = STS_BLOCKED;
        else if (run_mask[nd-1]) r.status = STS_RUNNING;
        else begin
          run_mask[nd-1] = 1'b1;
          r.status = STS_STARTED;
        end
      end
      OP_FINISH: begin
        if (node_in_use(nd)) begin
          fin_mask[nd-1] = 1'b1;
          // wake sequences whose head is a successor that just became ready
          if (cfg_auto && nd != n) begin
            for (int unsigned x = 0; x + 1 < n; x++) begin
              if (prec_rows[x][nd-1]) begin
                for (int unsigned i = 0; i + 1 < s; i++) begin
                  if (head_nodes[i] == x + 2 && preds_done(x + 2)) wake.push_back(i + 1);
                end
              end
            end
          end
        end
      end
      OP_CHECK: begin
        if (node_in_use(nd)) r.ready_res = preds_done(nd);
      end
      OP_WRITE_ROW: begin
        if (nd >= 2 && node_in_use(nd)) prec_rows[nd-2] = bits;
      end
      OP_WRITE_HEAD: begin
        if (slot < SLOTS) head_nodes[slot] = node;
      end
      default: ;
    endcase
    if (wake.size() == 0) begin
      pending_results.push_back(r);
    end else begin
      foreach (wake[k]) begin
        r.signal_valid    = 1'b1;
        r.signal_sequence = SEQ_W'(wake[k]);
        r.last            = (k == wake.size() - 1);
        pending_results.push_back(r);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: result words first, then register writes, then request words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 4'(want.status), 4'(res_if.status));
          check_field("ready_res", 4'(want.ready_res), 4'(res_if.ready_res));
          check_field("signal_valid", 4'(want.signal_valid), 4'(res_if.signal_valid));
          check_field("signal_sequence", 4'(want.signal_sequence),
                      4'(res_if.signal_sequence));
          check_field("last", 4'(want.last), 4'(res_if.last));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_e'(cfg_if.index))
          CFG_NODE_COUNT:  cfg_nodes = cfg_if.data;
          CFG_SEQ_COUNT:   cfg_seqs  = cfg_if.data[SCNT_W-1:0];
          CFG_AUTO_SIGNAL: cfg_auto  = cfg_if.data[0];
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        track_dispatch(req_if.operation, req_if.node, req_if.row_bits, req_if.head_slot);
        if (pin_on) begin
          void'(pending_results.pop_back());
          pending_results.push_back(pin_res);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic put_word(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node,
                          input logic [RBITS_W-1:0] bits, input logic [HSLOT_W-1:0] slot,
                          input bit pinned = 1'b0, input result_t fixed = '0);
    @(negedge clk_i);
    pin_on  = pinned;
    pin_res = fixed;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.node      <= node;
    req_if.row_bits  <= bits;
    req_if.head_slot <= slot;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    words_sent++;
  endtask

  // Random junk word: any opcode, any field value
  task automatic put_noise();
    put_word(OP_W'($urandom_range(7)), NODE_W'($urandom_range(31)), RBITS_W'($urandom),
             HSLOT_W'($urandom_range(7)));
  endtask

  // Stop offering words and wait for every expected result word
  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CDAT_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // One random job: settings, graph tables, new job, then start/finish walk
  task automatic run_job(input bit hold);
    logic [CDAT_W-1:0]  raw_n;
    logic [CDAT_W-1:0]  raw_s;
    int unsigned        n;
    int unsigned        j;
    int unsigned        tmp;
    int unsigned        order [$];
    logic [RBITS_W-1:0] b;
    drain();
    case ($urandom_range(9))
      0:       raw_n = CDAT_W'(MAX_NODES);
      1:       raw_n = ($urandom_range(1)) ? 5'd0 : 5'($urandom_range(17, 31));
      2:       raw_n = 5'd1;
      default: raw_n = 5'($urandom_range(2, 7));
    endcase
    case ($urandom_range(7))
      0:       raw_s = 5'd0;
      1:       raw_s = 5'($urandom_range(9, 15));
      default: raw_s = 5'($urandom_range(1, MAX_SEQUENCES));
    endcase
    write_reg(CFG_NODE_COUNT, raw_n);
    write_reg(CFG_SEQ_COUNT, raw_s);
    write_reg(CFG_AUTO_SIGNAL, 5'($urandom_range(3) != 0));
    if (hold) stall_req++;
    n = (raw_n < 1) ? 1 : (raw_n > MAX_NODES) ? MAX_NODES : 32'(raw_n);

    // predecessor rows point back but for an occasional fully random row
    for (int unsigned k = 2; k <= n; k++) begin
      b = RBITS_W'($urandom & $urandom & ((1 << (k - 1)) - 1));
      if ($urandom_range(7) == 0) b = RBITS_W'($urandom);
      put_word(OP_WRITE_ROW, NODE_W'(k), b, HSLOT_W'($urandom_range(7)));
    end
    for (int unsigned k = 0; k < SLOTS; k++) begin
      if ($urandom_range(7) == 0) begin
        put_word(OP_WRITE_HEAD, NODE_W'($urandom_range(31)), RBITS_W'($urandom),
                 HSLOT_W'(k));
      end else begin
        put_word(OP_WRITE_HEAD, NODE_W'((n < 2) ? 1 : $urandom_range(2, n)),
                 RBITS_W'($urandom), HSLOT_W'(k));
      end
    end
    put_word(OP_NEW_JOB, NODE_W'($urandom_range(31)), RBITS_W'($urandom),
             HSLOT_W'($urandom_range(7)));

    for (int unsigned k = 1; k <= n; k++) order.push_back(k);
    if ($urandom_range(3) == 0) begin
      foreach (order[k]) begin
        j        = $urandom_range(order.size() - 1);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
    end
    foreach (order[k]) begin
      if ($urandom_range(9) == 0) put_noise();
      if ($urandom_range(2) == 0)
        put_word(OP_CHECK, NODE_W'(order[k]), RBITS_W'($urandom),
                 HSLOT_W'($urandom_range(7)));
      put_word(OP_TRY_START, NODE_W'(order[k]), RBITS_W'($urandom),
               HSLOT_W'($urandom_range(7)));
      if ($urandom_range(4) == 0)
        put_word(OP_TRY_START, NODE_W'(order[k]), RBITS_W'($urandom),
                 HSLOT_W'($urandom_range(7)));
      if ($urandom_range(7) != 0)
        put_word(OP_FINISH, NODE_W'(order[k]), RBITS_W'($urandom),
                 HSLOT_W'($urandom_range(7)));
    end
  endtask

  // Plan rows
  function automatic step_t req(logic [OP_W-1:0] op, logic [NODE_W-1:0] node,
                                logic [RBITS_W-1:0] bits, logic [HSLOT_W-1:0] slot);
    step_t s;
    s      = '0;
    s.op   = op;
    s.node = node;
    s.bits = bits;
    s.slot = slot;
    return s;
  endfunction

  function automatic step_t req_pin(logic [OP_W-1:0] op, logic [NODE_W-1:0] node,
                                    logic [RBITS_W-1:0] bits, logic [HSLOT_W-1:0] slot,
                                    status_e st, bit rdy);
    step_t s;
    s             = req(op, node, bits, slot);
    s.pinned      = 1'b1;
    s.want_status = st;
    s.want_ready  = rdy;
    return s;
  endfunction

  function automatic step_t set_reg(cfg_idx_e idx, logic [CDAT_W-1:0] val);
    step_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    result_t fixed;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = '0;
    req_if.node      = '0;
    req_if.row_bits  = '0;
    req_if.head_slot = '0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_NODE_COUNT;
    cfg_if.data      = '0;
    fin_mask         = '0;
    run_mask         = '0;
    foreach (prec_rows[k]) prec_rows[k] = '0;
    foreach (head_nodes[k]) head_nodes[k] = '0;
    cfg_nodes        = NCNT_W'(MAX_NODES);
    cfg_seqs         = SCNT_W'(1);
    cfg_auto         = 1'b1;
    mismatch_cnt     = 0;
    words_sent       = 0;
    pin_on           = 1'b0;
    pin_res          = '0;
    stall_req        = 0;
    stall_seen       = 0;
    hold_left        = 0;
    src_idle_pct     = 14;
    snk_idle_pct     = 84;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, starting from reset settings: 16 nodes, one sequence, auto on
    plan = '{
      req_pin(OP_CHECK,      5'd1,  15'h0000, 3'd0, STS_ACK,     1'b1),
      req_pin(OP_TRY_START,  5'd0,  15'h7FFF, 3'd7, STS_BLOCKED, 1'b0),
      req_pin(OP_TRY_START,  5'd31, 15'h0000, 3'd0, STS_BLOCKED, 1'b0),
      req_pin(OP_TRY_START,  5'd1,  15'h0000, 3'd0, STS_STARTED, 1'b0),
      req_pin(OP_TRY_START,  5'd1,  15'h7FFF, 3'd7, STS_RUNNING, 1'b0),
      req_pin(OP_RSVD_A,     5'd16, 15'h7FFF, 3'd7, STS_ACK,     1'b0),
      req_pin(OP_RSVD_B,     5'd0,  15'h0000, 3'd0, STS_ACK,     1'b0),
      req_pin(OP_WRITE_ROW,  5'd1,  15'h7FFF, 3'd0, STS_ACK,     1'b0),
      req_pin(OP_WRITE_ROW,  5'd16, 15'h7FFF, 3'd0, STS_ACK,     1'b0),
      req_pin(OP_WRITE_ROW,  5'd3,  15'h0001, 3'd0, STS_ACK,     1'b0),
      req_pin(OP_WRITE_HEAD, 5'd3,  15'h0000, 3'd7, STS_ACK,     1'b0),
      req_pin(OP_WRITE_HEAD, 5'd3,  15'h0000, 3'd0, STS_ACK,     1'b0),
      req_pin(OP_WRITE_HEAD, 5'd16, 15'h0000, 3'd6, STS_ACK,     1'b0),
      req_pin(OP_CHECK,      5'd3,  15'h0000, 3'd0, STS_ACK,     1'b0),
      set_reg(CFG_SEQ_COUNT, 5'd15),
      req(OP_TRY_START, 5'd3, 15'h0000, 3'd0),
      req(OP_FINISH,    5'd1, 15'h0000, 3'd0),
      req(OP_CHECK,     5'd3, 15'h0000, 3'd0),
      req_pin(OP_FINISH,     5'd0,  15'h0000, 3'd0, STS_ACK,     1'b0),
      set_reg(CFG_NODE_COUNT, 5'd0),
      req(OP_FINISH,    5'd1, 15'h0000, 3'd0),
      set_reg(CFG_NODE_COUNT, 5'd31),
      set_reg(CFG_AUTO_SIGNAL, 5'd0),
      req(OP_FINISH,    5'd2, 15'h0000, 3'd0),
      set_reg(CFG_AUTO_SIGNAL, 5'd1),
      set_reg(CFG_NODE_COUNT, 5'd4),
      req(OP_WRITE_ROW, 5'd4, 15'h7FF8, 3'd0),
      req(OP_CHECK,     5'd4, 15'h0000, 3'd0),
      req_pin(OP_NEW_JOB,    5'd31, 15'h7FFF, 3'd7, STS_ACK,     1'b0),
      req_pin(OP_CHECK,      5'd3,  15'h0000, 3'd0, STS_ACK,     1'b0)
    };
    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        drain();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        fixed = '{status: plan[k].want_status, ready_res: plan[k].want_ready,
                  signal_valid: 1'b0, signal_sequence: '0, last: 1'b1};
        put_word(plan[k].op, plan[k].node, plan[k].bits, plan[k].slot, plan[k].pinned, fixed);
      end
    end

    // Random jobs: slow receiver, then slow sender, then full rate with a hold-off
    while (words_sent < 100) run_job(1'b0);
    src_idle_pct = 84;
    snk_idle_pct = 14;
    while (words_sent < 175) run_job(1'b0);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_job(1'b1);
    while (words_sent < 240) run_job(1'b0);

    // Let stray result words show up before the verdict
    drain();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dnd_pkg.sv
rtl/dnd_if.sv
rtl/dag_node_dispatch_tracker.sv
rtl/dnd_checker.sv
test/tb_dag_node_dispatch_tracker.sv
